[hdl/assert_macros.svh]
// shared assertion macros for the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form with explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// form bound to the usual clock and reset names
`define ASSERT_STD(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

[hdl/hisq_pkg.sv]
package hisq_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITER  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam int PI_Q      = 25736;
  localparam int HALF_PI_Q = 12868;
  localparam int TWO_PI_Q  = 51472;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BRAKE = 2'd1;
  localparam logic [1:0] PH_ALIGN = 2'd2;
  localparam logic [1:0] PH_SHOOT = 2'd3;

  localparam logic [1:0] CMD_ODOM  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] CFG_NEAR_RADIUS   = 3'd0;
  localparam logic [2:0] CFG_BRAKE_SPEED   = 3'd1;
  localparam logic [2:0] CFG_SETTLE_SPEED  = 3'd2;
  localparam logic [2:0] CFG_YAW_TOLERANCE = 3'd3;
  localparam logic [2:0] CFG_HOLD_TICKS    = 3'd4;
  localparam logic [2:0] CFG_SHOOT_TICKS   = 3'd5;

  // request to the angle unit
  typedef struct packed {
    logic               start;
    logic signed [32:0] x;
    logic signed [32:0] y;
  } cord_req_t;

  // arctangent of 2^-i, scaled by 2^30
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one wrap step into [-pi, pi], enough for the ranges used here
  function automatic logic signed [15:0] wrap_pi(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > 18'(PI_Q)) r = a - 18'(TWO_PI_Q);
    else if (a < -18'(PI_Q)) r = a + 18'(TWO_PI_Q);
    return r[15:0];
  endfunction

endpackage

[hdl/hisq_mul.sv]
module hisq_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic        [63:0] p_o
);
  logic signed [65:0] full;
  logic        [63:0] p_q;

  assign full = a_i * b_i;

  // only the low 64 bits of the product are kept
  always_ff @(posedge clk_i) begin
    p_q <= full[63:0];
  end

  assign p_o = p_q;
endmodule

[hdl/hisq_cordic.sv]
`include "assert_macros.svh"

module hisq_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hisq_pkg::cord_req_t req_i,
  output logic                done_o,
  output logic signed [15:0]  angle_o
);
  import hisq_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  logic [1:0]         cst_q;
  logic [41:0]        ax_q, ay_q;
  logic signed [43:0] cx_q, cy_q;
  logic signed [32:0] z_q;
  logic [4:0]         i_q;
  logic               xneg_q, yneg_q, done_q;
  logic signed [15:0] angle_q;

  logic [32:0]        xm, ym;
  logic signed [43:0] tx, ty;
  logic signed [32:0] tab, zc, zr;
  logic [15:0]        qa;
  logic signed [15:0] qs;

  assign xm  = req_i.x[32] ? 33'(-req_i.x) : 33'(req_i.x);
  assign ym  = req_i.y[32] ? 33'(-req_i.y) : 33'(req_i.y);
  assign tx  = cx_q >>> i_q;
  assign ty  = cy_q >>> i_q;
  assign tab = {3'b000, atan_entry(i_q)};

  always_comb begin
    zc = z_q[32] ? '0 : z_q;
    zr = (zc + 33'sd65536) >>> 17;
    qa = (zr > 33'(HALF_PI_Q)) ? 16'(HALF_PI_Q) : zr[15:0];
    if (xneg_q) qa = 16'(PI_Q) - qa;
    qs = yneg_q ? -$signed(qa) : $signed(qa);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q   <= C_IDLE;
      ax_q    <= '0;
      ay_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      z_q     <= '0;
      i_q     <= '0;
      xneg_q  <= 1'b0;
      yneg_q  <= 1'b0;
      done_q  <= 1'b0;
      angle_q <= '0;
    end else begin
      // done pulses after the final step, or at once for a zero vector
      done_q <= (cst_q == C_FIN) ||
                (cst_q == C_IDLE && req_i.start && xm == '0 && ym == '0);
      case (cst_q)
        C_IDLE: begin
          if (req_i.start) begin
            xneg_q <= req_i.x[32];
            yneg_q <= req_i.y[32];
            ax_q   <= {9'd0, xm};
            ay_q   <= {9'd0, ym};
            if (xm == '0 && ym == '0) begin
              angle_q <= '0;
            end else begin
              cst_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          // one bit of normalization per cycle
          if ((ax_q[41:40] | ay_q[41:40]) == 2'b00) begin
            ax_q <= {ax_q[40:0], 1'b0};
            ay_q <= {ay_q[40:0], 1'b0};
          end else begin
            cx_q  <= {2'b00, ax_q};
            cy_q  <= {2'b00, ay_q};
            z_q   <= '0;
            i_q   <= '0;
            cst_q <= C_ROT;
          end
        end
        C_ROT: begin
          if (!cy_q[43]) begin
            cx_q <= cx_q + ty;
            cy_q <= cy_q - tx;
            z_q  <= z_q + tab;
          end else begin
            cx_q <= cx_q - ty;
            cy_q <= cy_q + tx;
            z_q  <= z_q - tab;
          end
          i_q <= i_q + 5'd1;
          if (i_q == 5'(CORDIC_ITER - 1)) cst_q <= C_FIN;
        end
        C_FIN: begin
          angle_q <= qs;
          cst_q   <= C_IDLE;
        end
        default: cst_q <= C_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

  `ASSERT_STD(a_start_when_idle, req_i.start |-> (cst_q == C_IDLE))
  `ASSERT_STD(a_done_single, done_o |=> !done_o)
endmodule

[hdl/hover_inspect_sequencer_unit.sv]
// channel  | direction | handshake                  | content
// in       | input     | in_valid_i / in_stall_o    | command, coordinates, velocity, quaternion
// out      | output    | out_valid_o / out_stall_i  | phase, finished, yaw setpoint, target
// cfg      | input     | cfg_valid_i / cfg_ready_o  | register index and data
//
// one word in at a time; in_stall_o is high until its result is in the output register
// the next word can be accepted in the cycle after the output register load
// odometry: four quaternion products, then the angle unit normalizes and rotates
// start: a defect axis check, distance squares unless it already aims, angle unit when it aims
// tick: the shared multiplier does three squares in turn
// reset clears all state but the multiplier product register and restores register defaults
// no clearing pass; a held result on out does not block the next input word
`include "assert_macros.svh"

module hover_inspect_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_command_i,
  input  logic signed [31:0] in_coord_x_i,
  input  logic signed [31:0] in_coord_y_i,
  input  logic signed [31:0] in_coord_z_i,
  input  logic               in_defect_valid_i,
  input  logic signed [31:0] in_vel_north_i,
  input  logic signed [31:0] in_vel_east_i,
  input  logic signed [15:0] in_quat_w_i,
  input  logic signed [15:0] in_quat_x_i,
  input  logic signed [15:0] in_quat_y_i,
  input  logic signed [15:0] in_quat_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_phase_o,
  output logic               out_finished_o,
  output logic               out_setpoint_valid_o,
  output logic signed [15:0] out_yaw_setpoint_ned_o,
  output logic signed [31:0] out_target_x_o,
  output logic signed [31:0] out_target_y_o,
  output logic signed [31:0] out_target_z_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import hisq_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OMUL = 3'd1;  // quaternion products
  localparam logic [2:0] S_SCHK = 3'd2;  // defect axis check
  localparam logic [2:0] S_SMUL = 3'd3;  // defect distance squares
  localparam logic [2:0] S_TMUL = 3'd4;  // speed squares and tick update
  localparam logic [2:0] S_CORD = 3'd5;  // wait on the angle unit
  localparam logic [2:0] S_DONE = 3'd6;  // hand result to output register

  localparam logic [10:0] CNT_MAX = 11'd2047;

  // configuration
  logic [30:0] near_q, brake_q, settle_q;
  logic [14:0] tol_q;
  logic [9:0]  hold_ticks_q, shoot_ticks_q;

  // block state
  logic               have_odom_q;
  logic [1:0]         mode_q;
  logic signed [31:0] east_pos_q, north_pos_q, north_vel_q, east_vel_q;
  logic signed [15:0] heading_q, hold_q, aim_q;
  logic signed [31:0] def_x_q, def_y_q, def_z_q;
  logic [10:0]        steady_q, shoot_q;

  // sequencer working registers
  logic [2:0]         st_q;
  logic [2:0]         mcnt_q;
  logic [63:0]        acc_q;
  logic signed [31:0] num_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  logic               goal_head_q;

  // pending result
  logic [1:0]         res_phase_q;
  logic               res_fin_q, res_spv_q;
  logic signed [15:0] res_yaw_q;
  logic signed [31:0] res_tx_q, res_ty_q, res_tz_q;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_phase_q;
  logic               out_fin_q, out_spv_q;
  logic signed [15:0] out_yaw_q;
  logic signed [31:0] out_tx_q, out_ty_q, out_tz_q;

  logic               accept, out_free;
  logic signed [32:0] mul_a, mul_b;
  logic [63:0]        prod;
  cord_req_t          creq;
  logic               cdone;
  logic signed [15:0] cangle;

  logic signed [32:0] vn_mag, ve_mag;
  logic [32:0]        adx, ady, r33;
  logic signed [31:0] qsum;
  logic [31:0]        qsq;
  logic signed [31:0] den;
  logic signed [32:0] dx_in, dy_in;
  logic [63:0]        sq_sum;
  logic               slow, far;
  logic signed [16:0] err_d;
  logic [16:0]        err_a, err_w;
  logic [10:0]        steady_inc, steady_nx, shoot_nx;
  logic signed [15:0] sp;
  logic [30:0]        lim;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (st_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  hisq_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  hisq_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (creq),
    .done_o  (cdone),
    .angle_o (cangle)
  );

  // speed magnitudes and defect offsets
  assign vn_mag = north_vel_q[31] ? -{north_vel_q[31], north_vel_q}
                                  : {north_vel_q[31], north_vel_q};
  assign ve_mag = east_vel_q[31] ? -{east_vel_q[31], east_vel_q}
                                 : {east_vel_q[31], east_vel_q};
  assign adx    = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ady    = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign r33    = {2'b00, near_q};
  assign dx_in  = {in_coord_x_i[31], in_coord_x_i} - {east_pos_q[31], east_pos_q};
  assign dy_in  = {in_coord_y_i[31], in_coord_y_i} - {north_pos_q[31], north_pos_q};

  // quaternion sums: 2*(wz + xy) and 2^28 - 2*(yy + zz)
  assign qsum   = $signed(acc_q[31:0]) + $signed(prod[31:0]);
  assign qsq    = acc_q[31:0] + prod[31:0];
  assign den    = 32'sh1000_0000 - $signed({qsq[30:0], 1'b0});
  assign sq_sum = acc_q;
  assign slow   = sq_sum < prod;
  assign far    = sq_sum >= prod;
  assign lim    = (mode_q == PH_BRAKE) ? brake_q : settle_q;

  // multiplier operand select, one product per cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_OMUL: begin
        case (mcnt_q)
          3'd0: begin
            mul_a = {{17{qw_q[15]}}, qw_q};
            mul_b = {{17{qz_q[15]}}, qz_q};
          end
          3'd1: begin
            mul_a = {{17{qx_q[15]}}, qx_q};
            mul_b = {{17{qy_q[15]}}, qy_q};
          end
          3'd2: begin
            mul_a = {{17{qy_q[15]}}, qy_q};
            mul_b = {{17{qy_q[15]}}, qy_q};
          end
          3'd3: begin
            mul_a = {{17{qz_q[15]}}, qz_q};
            mul_b = {{17{qz_q[15]}}, qz_q};
          end
          default: ;
        endcase
      end
      S_SMUL: begin
        case (mcnt_q)
          3'd0: begin
            mul_a = $signed(adx);
            mul_b = $signed(adx);
          end
          3'd1: begin
            mul_a = $signed(ady);
            mul_b = $signed(ady);
          end
          3'd2: begin
            mul_a = $signed(r33);
            mul_b = $signed(r33);
          end
          default: ;
        endcase
      end
      S_TMUL: begin
        case (mcnt_q)
          3'd0: begin
            mul_a = vn_mag;
            mul_b = vn_mag;
          end
          3'd1: begin
            mul_a = ve_mag;
            mul_b = ve_mag;
          end
          3'd2: begin
            mul_a = $signed({2'b00, lim});
            mul_b = $signed({2'b00, lim});
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // angle unit requests
  always_comb begin
    creq.start = 1'b0;
    creq.x     = dx_q;
    creq.y     = dy_q;
    if (st_q == S_OMUL && mcnt_q == 3'd4) begin
      creq.start = 1'b1;
      creq.x     = {den[31], den};
      creq.y     = {num_q[31], num_q};
    end else if (st_q == S_SCHK && (adx >= r33 || ady >= r33)) begin
      creq.start = 1'b1;
    end else if (st_q == S_SMUL && mcnt_q == 3'd3 && far) begin
      creq.start = 1'b1;
    end
  end

  // tick phase logic: yaw error, debounce counters, setpoint
  always_comb begin
    err_d      = {aim_q[15], aim_q} - {heading_q[15], heading_q};
    err_a      = err_d[16] ? 17'(-err_d) : 17'(err_d);
    err_w      = (err_a > 17'(PI_Q)) ? 17'(TWO_PI_Q) - err_a : err_a;
    steady_inc = (steady_q < CNT_MAX) ? steady_q + 11'd1 : steady_q;
    steady_nx  = (slow && (err_w < {2'b00, tol_q})) ? steady_inc : '0;
    shoot_nx   = (shoot_q < CNT_MAX) ? shoot_q + 11'd1 : shoot_q;
    sp         = (mode_q == PH_BRAKE) ? hold_q : aim_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q        <= 31'd163840;
      brake_q       <= 31'd32768;
      settle_q      <= 31'd13107;
      tol_q         <= 15'd1229;
      hold_ticks_q  <= 10'd50;
      shoot_ticks_q <= 10'd150;
      have_odom_q   <= 1'b0;
      mode_q        <= PH_IDLE;
      east_pos_q    <= '0;
      north_pos_q   <= '0;
      north_vel_q   <= '0;
      east_vel_q    <= '0;
      heading_q     <= '0;
      hold_q        <= '0;
      aim_q         <= '0;
      def_x_q       <= '0;
      def_y_q       <= '0;
      def_z_q       <= '0;
      steady_q      <= '0;
      shoot_q       <= '0;
      st_q          <= S_IDLE;
      mcnt_q        <= '0;
      acc_q         <= '0;
      num_q         <= '0;
      dx_q          <= '0;
      dy_q          <= '0;
      qw_q          <= '0;
      qx_q          <= '0;
      qy_q          <= '0;
      qz_q          <= '0;
      goal_head_q   <= 1'b0;
      res_phase_q   <= PH_IDLE;
      res_fin_q     <= 1'b0;
      res_spv_q     <= 1'b0;
      res_yaw_q     <= '0;
      res_tx_q      <= '0;
      res_ty_q      <= '0;
      res_tz_q      <= '0;
      out_valid_q   <= 1'b0;
      out_phase_q   <= PH_IDLE;
      out_fin_q     <= 1'b0;
      out_spv_q     <= 1'b0;
      out_yaw_q     <= '0;
      out_tx_q      <= '0;
      out_ty_q      <= '0;
      out_tz_q      <= '0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_NEAR_RADIUS:   near_q        <= cfg_data_i[30:0];
          CFG_BRAKE_SPEED:   brake_q       <= cfg_data_i[30:0];
          CFG_SETTLE_SPEED:  settle_q      <= cfg_data_i[30:0];
          CFG_YAW_TOLERANCE: tol_q         <= cfg_data_i[14:0];
          CFG_HOLD_TICKS:    hold_ticks_q  <= cfg_data_i[9:0];
          CFG_SHOOT_TICKS:   shoot_ticks_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end

      // output register drains independently of the sequencer
      if (out_valid_q && !out_stall_i && st_q != S_DONE) out_valid_q <= 1'b0;

      case (st_q)
        S_IDLE: begin
          if (accept) begin
            // a start after odometry reports the braking phase it enters
            res_phase_q <= (in_command_i == CMD_START && have_odom_q) ? PH_BRAKE : mode_q;
            res_fin_q   <= 1'b0;
            res_spv_q   <= 1'b0;
            res_yaw_q   <= '0;
            res_tx_q    <= '0;
            res_ty_q    <= '0;
            res_tz_q    <= '0;
            mcnt_q      <= '0;
            acc_q       <= '0;
            case (in_command_i)
              CMD_ODOM: begin
                east_pos_q  <= in_coord_x_i;
                north_pos_q <= in_coord_y_i;
                north_vel_q <= in_vel_north_i;
                east_vel_q  <= in_vel_east_i;
                have_odom_q <= 1'b1;
                qw_q        <= in_quat_w_i;
                qx_q        <= in_quat_x_i;
                qy_q        <= in_quat_y_i;
                qz_q        <= in_quat_z_i;
                goal_head_q <= 1'b1;
                st_q        <= S_OMUL;
              end
              CMD_START: begin
                if (have_odom_q) begin
                  hold_q      <= heading_q;
                  aim_q       <= heading_q;
                  mode_q      <= PH_BRAKE;
                  steady_q    <= '0;
                  shoot_q     <= '0;
                  goal_head_q <= 1'b0;
                  if (in_defect_valid_i) begin
                    def_x_q <= in_coord_x_i;
                    def_y_q <= in_coord_y_i;
                    def_z_q <= in_coord_z_i;
                    dx_q    <= dx_in;
                    dy_q    <= dy_in;
                    st_q    <= S_SCHK;
                  end else begin
                    st_q <= S_DONE;
                  end
                end else begin
                  st_q <= S_DONE;
                end
              end
              CMD_TICK: begin
                st_q <= (mode_q != PH_IDLE) ? S_TMUL : S_DONE;
              end
              default: st_q <= S_DONE;
            endcase
          end
        end
        S_OMUL: begin
          mcnt_q <= mcnt_q + 3'd1;
          case (mcnt_q)
            3'd1: acc_q <= prod;
            3'd2: num_q <= $signed({qsum[30:0], 1'b0});
            3'd3: acc_q <= prod;
            3'd4: st_q  <= S_CORD;
            default: ;
          endcase
        end
        S_SCHK: begin
          // either axis at or beyond the radius aims straight away
          st_q <= creq.start ? S_CORD : S_SMUL;
        end
        S_SMUL: begin
          mcnt_q <= mcnt_q + 3'd1;
          case (mcnt_q)
            3'd1: acc_q <= prod;
            3'd2: acc_q <= acc_q + prod;
            3'd3: st_q  <= far ? S_CORD : S_DONE;
            default: ;
          endcase
        end
        S_TMUL: begin
          mcnt_q <= mcnt_q + 3'd1;
          case (mcnt_q)
            3'd1: acc_q <= prod;
            3'd2: acc_q <= acc_q + prod;
            3'd3: begin
              res_phase_q <= mode_q;
              res_spv_q   <= 1'b1;
              res_yaw_q   <= wrap_pi(18'(HALF_PI_Q) - {{2{sp[15]}}, sp});
              case (mode_q)
                PH_BRAKE: begin
                  if (slow) mode_q <= PH_ALIGN;
                end
                PH_ALIGN: begin
                  steady_q <= steady_nx;
                  if (steady_nx > {1'b0, hold_ticks_q}) mode_q <= PH_SHOOT;
                end
                PH_SHOOT: begin
                  shoot_q <= shoot_nx;
                  if (shoot_nx > {1'b0, shoot_ticks_q}) begin
                    res_fin_q <= 1'b1;
                    res_tx_q  <= def_x_q;
                    res_ty_q  <= def_y_q;
                    res_tz_q  <= def_z_q;
                    mode_q    <= PH_IDLE;
                  end
                end
                default: ;
              endcase
              st_q <= S_DONE;
            end
            default: ;
          endcase
        end
        S_CORD: begin
          if (cdone) begin
            if (goal_head_q) begin
              heading_q <= wrap_pi(18'(HALF_PI_Q) - {{2{cangle[15]}}, cangle});
            end else begin
              aim_q <= cangle;
            end
            st_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_phase_q <= res_phase_q;
            out_fin_q   <= res_fin_q;
            out_spv_q   <= res_spv_q;
            out_yaw_q   <= res_yaw_q;
            out_tx_q    <= res_tx_q;
            out_ty_q    <= res_ty_q;
            out_tz_q    <= res_tz_q;
            st_q        <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_phase_o            = out_phase_q;
  assign out_finished_o         = out_fin_q;
  assign out_setpoint_valid_o   = out_spv_q;
  assign out_yaw_setpoint_ned_o = out_yaw_q;
  assign out_target_x_o         = out_tx_q;
  assign out_target_y_o         = out_ty_q;
  assign out_target_z_o         = out_tz_q;

  `ASSERT_STD(a_finish_shape,
    out_valid_o && out_finished_o |-> out_setpoint_valid_o && (out_phase_o == PH_SHOOT))
  `ASSERT_STD(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)
  `ASSERT_STD(a_yaw_range,
    out_valid_o |-> (out_yaw_setpoint_ned_o <= 16'(PI_Q)) &&
      (out_yaw_setpoint_ned_o >= -16'(PI_Q)))
endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hisq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 120;   // outlasts the worst odometry path

  // command code with no function in the block
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // one input word as the sender sees it
  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] cx, cy, cz;
    logic               dv;
    logic signed [31:0] vn, ve;
    logic signed [15:0] qw, qx, qy, qz;
  } seq_word_t;

  // one output word
  typedef struct {
    logic [1:0]         phase;
    logic               finished;
    logic               spv;
    logic signed [15:0] yaw;
    logic signed [31:0] tx, ty, tz;
  } sp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] in_command_i = '0;
  logic signed [31:0] in_coord_x_i = '0, in_coord_y_i = '0, in_coord_z_i = '0;
  logic in_defect_valid_i = 1'b0;
  logic signed [31:0] in_vel_north_i = '0, in_vel_east_i = '0;
  logic signed [15:0] in_quat_w_i = '0, in_quat_x_i = '0, in_quat_y_i = '0, in_quat_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [1:0] out_phase_o;
  logic out_finished_o, out_setpoint_valid_o;
  logic signed [15:0] out_yaw_setpoint_ned_o;
  logic signed [31:0] out_target_x_o, out_target_y_o, out_target_z_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;        // long receiver hold-off, counted down at each falling edge

  always #2 clk_i = ~clk_i;

  hover_inspect_sequencer_unit DUT (.*);

  // one line per mismatch, and count it
  task automatic report(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // predicts the sequencer words and holds the ones still owed by the block
  class setpoint_scoreboard;
    sp_word_t pending[$];
    longint atan_lut[24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

    // register copies
    bit [30:0] near_radius = 163840, brake_speed = 32768, settle_speed = 13107;
    bit [14:0] yaw_tol = 1229;
    bit [9:0]  hold_ticks = 50, shoot_ticks = 150;

    // sequencer copy
    bit have_odom;
    logic [1:0] mode = PH_IDLE;
    int east_pos, north_pos, north_vel, east_vel;
    int heading, hold_heading, aim_heading;
    int defect[3];
    int steady_cnt, shoot_cnt;

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_NEAR_RADIUS:   near_radius = val[30:0];
        CFG_BRAKE_SPEED:   brake_speed = val[30:0];
        CFG_SETTLE_SPEED:  settle_speed = val[30:0];
        CFG_YAW_TOLERANCE: yaw_tol = val[14:0];
        CFG_HOLD_TICKS:    hold_ticks = val[9:0];
        CFG_SHOOT_TICKS:   shoot_ticks = val[9:0];
        default: ;
      endcase
    endfunction

    function longint unsigned absval(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function int wrap_angle(int a);
      while (a > PI_Q) a -= TWO_PI_Q;
      while (a < -PI_Q) a += TWO_PI_Q;
      return a;
    endfunction

    // vectoring cordic, result Q3.13
    function int arctan2(longint y, longint x);
      longint unsigned ax, ay;
      longint cx, cy, z, tx, ty;
      int q;
      ax = absval(x);
      ay = absval(y);
      z = 0;
      if (ax == 0 && ay == 0) return 0;
      while ((ax | ay) < (64'd1 << 40)) begin
        ax <<= 1;
        ay <<= 1;
      end
      cx = longint'(ax);
      cy = longint'(ay);
      for (int i = 0; i < CORDIC_ITER; i++) begin
        tx = cx >>> i;
        ty = cy >>> i;
        if (cy >= 0) begin
          cx += ty; cy -= tx; z += atan_lut[i];
        end else begin
          cx -= ty; cy += tx; z -= atan_lut[i];
        end
      end
      if (z < 0) z = 0;
      q = int'((z + 65536) >>> 17);
      if (q > HALF_PI_Q) q = HALF_PI_Q;
      if (x < 0) q = PI_Q - q;
      if (y < 0) q = -q;
      return q;
    endfunction

    function bit below_speed(bit [30:0] limit);
      longint unsigned a, b;
      a = absval(north_vel);
      b = absval(east_vel);
      return a * a + b * b < 64'(limit) * 64'(limit);
    endfunction

    function void note_input(seq_word_t w);
      sp_word_t r;
      longint qw, qx, qy, qz, num, den, dx, dy;
      longint unsigned adx, ady, rad;
      int err, sp;
      r = '{default: '0};
      r.phase = mode;
      if (w.cmd == CMD_ODOM) begin
        qw = w.qw; qx = w.qx; qy = w.qy; qz = w.qz;
        num = 2 * (qw * qz + qx * qy);
        den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        east_pos = w.cx; north_pos = w.cy;
        north_vel = w.vn; east_vel = w.ve;
        heading = wrap_angle(HALF_PI_Q - arctan2(num, den));
        have_odom = 1'b1;
        r.phase = mode;
      end else if (w.cmd == CMD_START) begin
        // ignored until the first odometry word
        if (have_odom) begin
          hold_heading = heading;
          aim_heading = heading;
          if (w.dv) begin
            defect[0] = w.cx; defect[1] = w.cy; defect[2] = w.cz;
            dx = longint'(defect[0]) - east_pos;
            dy = longint'(defect[1]) - north_pos;
            adx = absval(dx); ady = absval(dy); rad = near_radius;
            if (adx >= rad || ady >= rad || adx * adx + ady * ady >= rad * rad)
              aim_heading = arctan2(dy, dx);
          end
          mode = PH_BRAKE;
          steady_cnt = 0;
          shoot_cnt = 0;
        end
        r.phase = mode;
      end else if (w.cmd == CMD_TICK && mode != PH_IDLE) begin
        err = aim_heading - heading;
        if (err < 0) err = -err;
        if (err > PI_Q) err = TWO_PI_Q - err;
        r.phase = mode;
        sp = aim_heading;
        case (mode)
          PH_BRAKE: begin
            sp = hold_heading;
            if (below_speed(brake_speed)) mode = PH_ALIGN;
          end
          PH_ALIGN: begin
            if (below_speed(settle_speed) && err < int'(yaw_tol)) begin
              if (steady_cnt < 2047) steady_cnt++;
            end else begin
              steady_cnt = 0;
            end
            if (steady_cnt > int'(hold_ticks)) mode = PH_SHOOT;
          end
          default: begin
            if (shoot_cnt < 2047) shoot_cnt++;
            if (shoot_cnt > int'(shoot_ticks)) begin
              r.finished = 1'b1;
              r.tx = defect[0]; r.ty = defect[1]; r.tz = defect[2];
              mode = PH_IDLE;
            end
          end
        endcase
        r.spv = 1'b1;
        r.yaw = 16'(wrap_angle(HALF_PI_Q - sp));
      end else begin
        r.phase = mode;
      end
      pending.push_back(r);
    endfunction

    task check(sp_word_t got);
      sp_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word, phase", got.phase, -1);
        return;
      end
      e = pending.pop_front();
      if (got.phase !== e.phase) report("phase", got.phase, e.phase);
      if (got.finished !== e.finished) report("finished", got.finished, e.finished);
      if (got.spv !== e.spv) report("setpoint_valid", got.spv, e.spv);
      if (got.yaw !== e.yaw) report("yaw_setpoint_ned", got.yaw, e.yaw);
      if (got.tx !== e.tx) report("target_x", got.tx, e.tx);
      if (got.ty !== e.ty) report("target_y", got.ty, e.ty);
      if (got.tz !== e.tz) report("target_z", got.tz, e.tz);
    endtask
  endclass

  setpoint_scoreboard sb = new();

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hover_inspect_sequencer_unit verification failed");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // output monitor, sampled at the rising edge
  always @(posedge clk_i) begin
    sp_word_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.phase = out_phase_o;
      got.finished = out_finished_o;
      got.spv = out_setpoint_valid_o;
      got.yaw = out_yaw_setpoint_ned_o;
      got.tx = out_target_x_o;
      got.ty = out_target_y_o;
      got.tz = out_target_z_o;
      sb.check(got);
    end
  end

  // offer one word, starting at a falling edge, and return at the falling edge after acceptance
  task automatic send_word(input seq_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_command_i = w.cmd;
    in_coord_x_i = w.cx; in_coord_y_i = w.cy; in_coord_z_i = w.cz;
    in_defect_valid_i = w.dv;
    in_vel_north_i = w.vn; in_vel_east_i = w.ve;
    in_quat_w_i = w.qw; in_quat_x_i = w.qx; in_quat_y_i = w.qy; in_quat_z_i = w.qz;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
    @(negedge clk_i);
  endtask

  // drop valid and let every owed word come back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // full register set, written only once the block is quiet
  task automatic load_regs(input logic [31:0] nr, bs, ss, tol, hold, shoot);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_NEAR_RADIUS, nr);
    write_reg(CFG_BRAKE_SPEED, bs);
    write_reg(CFG_SETTLE_SPEED, ss);
    write_reg(CFG_YAW_TOLERANCE, tol);
    write_reg(CFG_HOLD_TICKS, hold);
    write_reg(CFG_SHOOT_TICKS, shoot);
  endtask

  function automatic seq_word_t mk(logic [1:0] cmd, int cx, int cy, int cz, bit dv,
                                   int vn, int ve, int qw, int qx, int qy, int qz);
    seq_word_t w;
    w.cmd = cmd; w.cx = cx; w.cy = cy; w.cz = cz; w.dv = dv;
    w.vn = vn; w.ve = ve; w.qw = qw; w.qx = qx; w.qy = qy; w.qz = qz;
    return w;
  endfunction

  function automatic int rand_quat();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int rand_small(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // current attitude, mostly reused so the heading error can settle
  int cur_q[4] = '{16384, 0, 0, 0};

  // random word: mostly ticks with occasional odometry and starts, plus noise
  function automatic seq_word_t rand_word();
    seq_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w = mk(CMD_TICK, $urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom, $urandom,
           rand_quat(), rand_quat(), rand_quat(), rand_quat());
    if (r < 14) begin
      w.cmd = CMD_ODOM;
      if ($urandom_range(0, 9) < 7) begin
        w.cx = rand_small(1 << 20);
        w.cy = rand_small(1 << 20);
      end
      if ($urandom_range(0, 3) != 0) begin
        w.vn = rand_small(1 << 13);
        w.ve = rand_small(1 << 13);
      end
      if ($urandom_range(0, 4) == 0)
        foreach (cur_q[i]) cur_q[i] = rand_quat();
      w.qw = cur_q[0]; w.qx = cur_q[1]; w.qy = cur_q[2]; w.qz = cur_q[3];
    end else if (r < 20) begin
      w.cmd = CMD_START;
      if ($urandom_range(0, 1) == 0) begin
        w.cx = rand_small(1 << 21);
        w.cy = rand_small(1 << 21);
      end
    end else if (r < 22) begin
      w.cmd = CMD_SPARE;
    end
    return w;
  endfunction

  task automatic random_phase(input int count, input bit squeeze);
    int done;
    seq_word_t w;
    done = 0;
    while (done < count) begin
      // long receiver hold-off while words keep coming
      if (squeeze && done == count / 3) hold_off = 400;
      // sender pause until the block has returned everything
      if (squeeze && done == 2 * count / 3) drain_results();
      w = rand_word();
      send_word(w);
      if (w.cmd != CMD_SPARE) done++;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // short debounce so the directed run reaches success
    load_regs(163840, 32768, 13107, 1229, 2, 3);

    send_idle_pct = 21;
    recv_idle_pct = 73;
    // start before any odometry, tick while idle, unused command
    send_word(mk(CMD_START, 5, 6, 7, 1, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_SPARE, -1, -1, -1, 1, -1, -1, -1, -1, -1, -1));
    // attitude extremes and the degenerate arctangent
    send_word(mk(CMD_ODOM, 32'h80000000, 32'h7fffffff, 0, 0, 32'h80000000, 32'h7fffffff,
                 16384, 0, 0, 0));
    send_word(mk(CMD_ODOM, 32'h7fffffff, 32'h80000000, -1, 1, 32'h7fffffff, 32'h80000000,
                 -16384, -16384, -16384, -16384));
    send_word(mk(CMD_ODOM, 0, 0, 0, 0, 0, 0, 4096, -4096, 8192, 8192));
    send_word(mk(CMD_ODOM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16384));
    send_word(mk(CMD_ODOM, 0, 0, 0, 0, 0, 0, 16384, 16384, 16384, 16384));
    send_word(mk(CMD_ODOM, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // start without a defect keeps heading; run it through to success
    send_word(mk(CMD_START, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0));
    repeat (9) send_word(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // defect on the vehicle, then far away, then a restart mid-run
    send_word(mk(CMD_START, 0, 0, 99, 1, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_START, -655360, 655360, 5, 1, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_START, 32'h7fffffff, 32'h80000000, 32'h80000000, 1, 0, 0, 0, 0, 0, 0));
    send_word(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    random_phase(120, 1'b1);

    // zeros and maxima
    load_regs(0, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    send_idle_pct = 73;
    recv_idle_pct = 21;
    random_phase(70, 1'b0);
    load_regs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 25736, 1, 0);
    random_phase(70, 1'b0);

    load_regs($urandom_range(0, 300000), $urandom_range(20000, 60000),
              $urandom_range(9000, 20000), $urandom_range(2000, 25736),
              $urandom_range(0, 3), $urandom_range(0, 3));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(130, 1'b1);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("hover_inspect_sequencer_unit verification clean");
    end else begin
      $display("hover_inspect_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
